### hdl/pte_pkg.sv
// package for the penalized two-objective evaluator: payload types, constants, squared-sine table
`timescale 1ns / 1ps
package pte_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 23;
  localparam int BIAS_W     = 41;
  localparam int OBJ_W      = 62;
  localparam int SUM_W      = 61;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [22:0]        PEN_LIMIT  = 23'd327680;    // 5.0 in Q16
  localparam logic [23:0]        ONE_Q      = 24'd65536;
  localparam logic [17:0]        RECIP10_S  = 18'd209716;    // 2^21 / 10, rounded up
  localparam logic [31:0]        RECIP10_W  = 32'hCCCCCCCD;  // 2^35 / 10, rounded up

  typedef struct packed {
    logic signed [COORD_W-1:0] coordinate;
    logic                      last_coordinate;
  } in_item_t;

  typedef struct packed {
    logic signed [OBJ_W-1:0] objective;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic                      first;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // sin^2(pi*k/64), Q16; entries past the quarter point stay at one
  function automatic logic [16:0] sin2_entry(input logic [5:0] k);
    logic [16:0] v;
    unique case (k)
      6'd0:  v = 17'd0;      6'd1:  v = 17'd158;    6'd2:  v = 17'd630;
      6'd3:  v = 17'd1411;   6'd4:  v = 17'd2494;   6'd5:  v = 17'd3869;
      6'd6:  v = 17'd5522;   6'd7:  v = 17'd7438;   6'd8:  v = 17'd9598;
      6'd9:  v = 17'd11980;  6'd10: v = 17'd14563;  6'd11: v = 17'd17321;
      6'd12: v = 17'd20228;  6'd13: v = 17'd23256;  6'd14: v = 17'd26375;
      6'd15: v = 17'd29556;  6'd16: v = 17'd32768;  6'd17: v = 17'd35980;
      6'd18: v = 17'd39161;  6'd19: v = 17'd42280;  6'd20: v = 17'd45308;
      6'd21: v = 17'd48215;  6'd22: v = 17'd50973;  6'd23: v = 17'd53556;
      6'd24: v = 17'd55938;  6'd25: v = 17'd58098;  6'd26: v = 17'd60014;
      6'd27: v = 17'd61667;  6'd28: v = 17'd63042;  6'd29: v = 17'd64125;
      6'd30: v = 17'd64906;  6'd31: v = 17'd65378;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // fold a phase fraction onto [0, 1/2]
  function automatic logic [15:0] fold_phase(input logic [15:0] f);
    logic [16:0] r;
    r = 17'd65536 - {1'b0, f};
    return (f > 16'd32768) ? r[15:0] : f;
  endfunction

endpackage

### hdl/pte_fifo.sv
// short job queue between the front and the back
`timescale 1ns / 1ps
module pte_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pte_pkg::job_t wr_data,
  input  logic          pop,
  output pte_pkg::job_t rd_data,
  output pte_pkg::q_stat_t stat
);
  import pte_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/pte_front.sv
// front end: accepts coordinates, tracks vector position and marks first and last
`timescale 1ns / 1ps
module pte_front #(
  parameter int MAX_DIMENSIONS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  pte_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output pte_pkg::job_t     q_data
);
  import pte_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSIONS + 1);

  logic          first_r, first_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_inc;
  logic          eff_last;

  assign q_push    = in_push && !q_full;
  assign count_inc = count_r + 1'b1;
  // dimension cap forces the end of a vector
  assign eff_last  = in_data.last_coordinate || (count_inc >= CW'(MAX_DIMENSIONS));

  assign q_data.x     = in_data.coordinate;
  assign q_data.first = first_r;
  assign q_data.last  = eff_last;

  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    if (q_push) begin
      first_nxt = eff_last;
      count_nxt = eff_last ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      count_r <= '0;
    end else begin
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/pte_back.sv
// back end: term sequencer, saturating accumulator and result register
`timescale 1ns / 1ps
module pte_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pte_pkg::q_stat_t              q_stat,
  input  pte_pkg::job_t                 q_data,
  output logic                          q_pop,
  input  logic signed [pte_pkg::BIAS_W-1:0] bias,
  output pte_pkg::out_item_t            out_data,
  output logic                          out_valid,
  input  logic                          out_pop
);
  import pte_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_MUL1 = 8'b0000_0100,
    ST_RED1 = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_MUL3 = 8'b0010_0000,
    ST_ACC  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } st_t;

  st_t state_r, state_nxt;

  job_t             job_r;
  logic signed [COORD_W-1:0] prev_r;
  logic [SUM_W-1:0] sum_r;
  logic             sat_r;
  logic             ov_r;
  out_item_t        res_r;

  // datapath registers
  logic [16:0] t3_r, t2_r;
  logic [11:0] dl3_r, dl2_r;
  logic [9:0]  fr3_r, fr2_r;
  logic [22:0] dp_r, dx_r, e_r;
  logic        pen_r;
  logic [21:0] ip3_r, ip2_r;
  logic [45:0] dpsq_r, dxsq_r, esq_r;
  logic [16:0] s3_r, s2_r;
  logic [29:0] sqp_r, sqx_r, e2_r;
  logic [47:0] cpm_r, cxm_r;
  logic [59:0] e4m_r;
  logic [34:0] s3d_r;
  logic [63:0] cpr_r, cxr_r;
  logic [50:0] pen100_r;
  logic [13:0] s3q_r;

  // prep combinational
  logic [15:0] f3, f2;
  logic [16:0] t3n, t2n;
  logic [16:0] d3full, d2full;
  logic signed [23:0] dpdiff, dxdiff, dpneg, dxneg;
  logic [22:0] mx;
  logic signed [22:0] xneg;
  logic [22:0] ediff;

  // accumulate combinational
  logic [51:0]        term;
  logic [SUM_W:0]     total;
  logic [SUM_W-1:0]   sum_new;
  logic               sat_new;
  logic signed [SUM_W+1:0] obj;
  logic               obj_clip;

  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_data  = res_r;
  assign out_valid = ov_r;

  always_comb begin
    f3     = fold_phase(job_r.x[15:0] + {job_r.x[14:0], 1'b0});
    f2     = fold_phase({job_r.x[14:0], 1'b0});
    t3n    = sin2_entry(f3[15:10]);
    t2n    = sin2_entry(f2[15:10]);
    d3full = sin2_entry(f3[15:10] + 6'd1) - t3n;
    d2full = sin2_entry(f2[15:10] + 6'd1) - t2n;
    dpdiff = {prev_r[COORD_W-1], prev_r} - $signed(ONE_Q);
    dxdiff = {job_r.x[COORD_W-1], job_r.x} - $signed(ONE_Q);
    dpneg  = -dpdiff;
    dxneg  = -dxdiff;
    xneg   = -job_r.x;
    mx     = job_r.x[COORD_W-1] ? xneg : job_r.x;
    ediff  = mx - PEN_LIMIT;
  end

  always_comb begin
    term    = {38'd0, job_r.first ? s3q_r : 14'd0}
            + {23'd0, job_r.first ? 29'd0 : cpr_r[63:35]}
            + {1'b0, pen100_r}
            + {23'd0, job_r.last ? cxr_r[63:35] : 29'd0};
    total   = {1'b0, sum_r} + {{(SUM_W-51){1'b0}}, term};
    sat_new = sat_r || (total > {1'b0, SUM_MAX});
    sum_new = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
    obj      = $signed({2'b00, sum_r}) + (SUM_W+2)'(bias);
    obj_clip = (obj > $signed({2'b00, SUM_MAX}));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_stat.empty) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_RED1;
      ST_RED1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = job_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (!ov_r || out_pop) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    if (state_r == ST_PREP) begin
      t3_r  <= t3n;
      t2_r  <= t2n;
      dl3_r <= d3full[11:0];
      dl2_r <= d2full[11:0];
      fr3_r <= f3[9:0];
      fr2_r <= f2[9:0];
      dp_r  <= dpdiff[23] ? dpneg[22:0] : dpdiff[22:0];
      dx_r  <= dxdiff[23] ? dxneg[22:0] : dxdiff[22:0];
      pen_r <= mx > PEN_LIMIT;
      e_r   <= ediff;
    end
    if (state_r == ST_MUL1) begin
      ip3_r  <= dl3_r * fr3_r;
      ip2_r  <= dl2_r * fr2_r;
      dpsq_r <= dp_r * dp_r;
      dxsq_r <= dx_r * dx_r;
      esq_r  <= e_r * e_r;
    end
    if (state_r == ST_RED1) begin
      s3_r  <= t3_r + {5'd0, ip3_r[21:10]};
      s2_r  <= t2_r + {5'd0, ip2_r[21:10]};
      sqp_r <= dpsq_r[45:16];
      sqx_r <= dxsq_r[45:16];
      e2_r  <= esq_r[45:16];
    end
    if (state_r == ST_MUL2) begin
      cpm_r <= sqp_r * (18'd65536 + {1'b0, s3_r});
      cxm_r <= sqx_r * (18'd65536 + {1'b0, s2_r});
      e4m_r <= e2_r * e2_r;
      s3d_r <= s3_r * RECIP10_S;
    end
    if (state_r == ST_MUL3) begin
      cpr_r    <= cpm_r[47:16] * RECIP10_W;
      cxr_r    <= cxm_r[47:16] * RECIP10_W;
      pen100_r <= pen_r ? e4m_r[59:16] * 7'd100 : 51'd0;
      s3q_r    <= s3d_r[34:21];
    end
    if (state_r == ST_EMIT && (!ov_r || out_pop)) begin
      res_r.objective <= obj_clip ? {1'b0, SUM_MAX} : obj[OBJ_W-1:0];
      res_r.saturated <= sat_r || obj_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      sum_r   <= '0;
      sat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC) begin
        prev_r <= job_r.x;
        sum_r  <= sum_new;
        sat_r  <= sat_new;
      end
      if (state_r == ST_EMIT && (!ov_r || out_pop)) begin
        ov_r  <= 1'b1;
        sum_r <= '0;
        sat_r <= 1'b0;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/penalized_two_objective_eval_top.sv
// top level of the penalized function 2 evaluator
`timescale 1ns / 1ps
// usage
//   input queue: drive in_data and raise in_push; a transfer happens at a rising edge
//   with in_push high and in_full low. coordinates of one vector come in order,
//   last_coordinate marks the final one (MAX_DIMENSIONS coordinates also end a vector)
//   result queue: while out_empty is low, out_data holds the oldest objective;
//   raising out_pop transfers it. one result per vector
//   config: cfg_wr_en with cfg_wr_data writes the Q16 objective bias at that edge;
//   write only while the block is idle
//   sequencing: the back end takes one coordinate at a time through idle pickup,
//   prep, multiply, reduce, second multiply, reciprocal multiply and accumulate,
//   plus an emit step on the last coordinate, held while an unread result waits
//   result path: with the back idle and the result slot free, the last coordinate
//   goes through the job queue and every step above; out_empty drops after emit
//   the 4-entry job queue lets the front take coordinates while the back works
//   reset: synchronous active-low; clears the queue, the running sum, the bias
//   and the result valid flag, and the block expects a first coordinate
//   stall: if out_pop stays low while a result is held, the back holds in its emit
//   step, the queue fills and in_full rises; nothing is lost
module penalized_two_objective_eval_top #(
  parameter int MAX_DIMENSIONS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  pte_pkg::in_item_t                  in_data,
  output logic                               in_full,
  output logic                               out_empty,
  output pte_pkg::out_item_t                 out_data,
  input  logic                               out_pop,
  input  logic                               cfg_wr_en,
  input  logic signed [pte_pkg::BIAS_W-1:0]  cfg_wr_data
);
  import pte_pkg::*;

  // bias register
  logic signed [BIAS_W-1:0] bias_r;

  // front to queue
  logic    q_push;
  job_t    q_wdata;
  // queue to back
  job_t    q_rdata;
  logic    q_pop;
  q_stat_t q_stat;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_wr_en) begin
      bias_r <= cfg_wr_data;
    end
  end

  assign in_full   = q_stat.full;
  assign out_empty = !out_valid;

  // classify coordinates: first of a vector, last of a vector
  pte_front #(
    .MAX_DIMENSIONS(MAX_DIMENSIONS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_stat.full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // decoupling queue
  pte_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  // term evaluation and accumulation
  pte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .bias      (bias_r),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_pop   (out_pop)
  );

  // result never exceeds the clip ceiling
  a_obj_clip: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.objective <= $signed({1'b0, SUM_MAX})))
    else $error("objective above ceiling");

  // queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> out_empty)
    else $error("result present after reset");

endmodule
